[rtl/m3sra_pkg.sv]
// shared types, constants and helpers for the median-of-three scaled rolling average
package m3sra_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int WORD_W        = 16;
    localparam int DIVISOR_W     = 8;
    localparam int PROD_W        = 17;
    localparam int DIVIDEND_W    = 18;
    localparam int STEP_CNT_W    = 5;
    localparam int RING_DEPTH    = 3;
    localparam int SLOT_W        = 2;
    localparam int NZ_CNT_W      = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    localparam logic [6:0]           SCALE_MUL     = 7'd100;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 8'd29;
    localparam logic [WORD_W-1:0]    WORD_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_first;
        logic [SAMPLE_W-1:0] sample_second;
        logic [SAMPLE_W-1:0] sample_third;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] scaled_value;
        logic [WORD_W-1:0] mean_of_nonzero;
    } t_out_item;

    // front to back: oldest queued median
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] median;
    } t_med_item;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [SAMPLE_W-1:0] median3(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c
    );
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end else if (c >= hi) begin
            return hi;
        end else begin
            return c;
        end
    endfunction

endpackage

[rtl/m3sra_front.sv]
// front end: takes sample triples, picks the median and queues it for the back end
module m3sra_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  m3sra_pkg::t_in_item i_in_item,
    output m3sra_pkg::t_med_item o_med,
    input  logic                i_med_take
);

    logic [m3sra_pkg::SAMPLE_W-1:0]    r_q [m3sra_pkg::QUEUE_DEPTH];
    logic [m3sra_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [m3sra_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [m3sra_pkg::QUEUE_CNT_W-1:0] r_count;
    logic [m3sra_pkg::QUEUE_CNT_W-1:0] n_count;
    logic                              w_wr;
    logic                              w_rd;

    assign full  = (r_count == m3sra_pkg::QUEUE_CNT_W'(m3sra_pkg::QUEUE_DEPTH));
    assign w_wr  = push && !full;
    assign w_rd  = i_med_take && (r_count != '0);

    assign o_med.valid  = (r_count != '0);
    assign o_med.median = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= m3sra_pkg::median3(i_in_item.sample_first,
                                                i_in_item.sample_second,
                                                i_in_item.sample_third);
        end
    end

endmodule

[rtl/m3sra_div.sv]
// restoring divider, one quotient bit per cycle
module m3sra_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  m3sra_pkg::t_div_req  i_req,
    output m3sra_pkg::t_div_rsp  o_rsp
);

    logic [m3sra_pkg::DIVIDEND_W-1:0] r_quo;
    logic [m3sra_pkg::DIVISOR_W-1:0]  r_rem;
    logic [m3sra_pkg::DIVISOR_W-1:0]  r_div;
    logic [m3sra_pkg::STEP_CNT_W-1:0] r_cnt;
    logic                             r_busy;
    logic                             r_done;

    logic [m3sra_pkg::DIVISOR_W:0]    w_trial;
    logic [m3sra_pkg::DIVISOR_W:0]    w_diff;
    logic                             w_bit;

    assign w_trial = {r_rem, r_quo[m3sra_pkg::DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_bit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == m3sra_pkg::STEP_CNT_W'(m3sra_pkg::DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[m3sra_pkg::DIVIDEND_W-2:0], w_bit};
            r_rem <= w_bit ? w_diff[m3sra_pkg::DIVISOR_W-1:0]
                           : w_trial[m3sra_pkg::DIVISOR_W-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[rtl/m3sra_back.sv]
// back end: scales the median, updates the ring and forms the mean of nonzero entries
module m3sra_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  m3sra_pkg::t_med_item            i_med,
    output logic                            o_med_take,
    input  logic [m3sra_pkg::DIVISOR_W-1:0] i_scale_divisor,
    output logic                            empty,
    input  logic                            pop,
    output m3sra_pkg::t_out_item            o_out_item
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCALE = 6'b000010,
        ST_STORE = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_MEAN  = 6'b010000,
        ST_HOLD  = 6'b100000
    } t_state;

    t_state                                r_state;
    t_state                                n_state;
    logic [m3sra_pkg::WORD_W-1:0]          r_ring [m3sra_pkg::RING_DEPTH];
    logic [m3sra_pkg::SLOT_W-1:0]          r_slot;
    logic [m3sra_pkg::WORD_W-1:0]          r_scaled;
    logic [m3sra_pkg::WORD_W-1:0]          r_mean;

    m3sra_pkg::t_div_req                   w_div_req;
    m3sra_pkg::t_div_rsp                   w_div_rsp;
    logic [m3sra_pkg::PROD_W-1:0]          w_prod;
    logic [m3sra_pkg::DIVIDEND_W-1:0]      w_sum;
    logic [m3sra_pkg::NZ_CNT_W-1:0]        w_nz_cnt;
    logic [m3sra_pkg::SLOT_W-1:0]          w_wr_idx;
    logic [m3sra_pkg::WORD_W-1:0]          w_sat_quo;

    m3sra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_prod = m3sra_pkg::PROD_W'(i_med.median) * m3sra_pkg::PROD_W'(m3sra_pkg::SCALE_MUL);

    // divisor of one can push the quotient past 16 bits
    assign w_sat_quo = (w_div_rsp.quotient[m3sra_pkg::DIVIDEND_W-1:m3sra_pkg::WORD_W] != '0)
                       ? m3sra_pkg::WORD_MAX
                       : w_div_rsp.quotient[m3sra_pkg::WORD_W-1:0];

    always_comb begin
        w_sum    = '0;
        w_nz_cnt = '0;
        for (int k = 0; k < m3sra_pkg::RING_DEPTH; k++) begin
            if (r_ring[k] != '0) begin
                w_sum    = w_sum + m3sra_pkg::DIVIDEND_W'(r_ring[k]);
                w_nz_cnt = w_nz_cnt + 1'b1;
            end
        end
    end

    assign w_wr_idx = (r_slot == m3sra_pkg::SLOT_W'(m3sra_pkg::RING_DEPTH)) ? '0 : r_slot;

    always_comb begin
        n_state            = r_state;
        o_med_take         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = m3sra_pkg::DIVIDEND_W'(w_prod);
        w_div_req.divisor  = i_scale_divisor;
        unique case (r_state)
            ST_IDLE: begin
                if (i_med.valid) begin
                    o_med_take = 1'b1;
                    if (i_scale_divisor == '0) begin
                        n_state = ST_STORE;
                    end else begin
                        w_div_req.start = 1'b1;
                        n_state         = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (w_div_rsp.done) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                w_div_req.dividend = w_sum;
                w_div_req.divisor  = m3sra_pkg::DIVISOR_W'(w_nz_cnt);
                if (w_nz_cnt == '0) begin
                    n_state = ST_HOLD;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (w_div_rsp.done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            for (int k = 0; k < m3sra_pkg::RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_STORE) begin
                r_ring[w_wr_idx] <= r_scaled;
                r_slot <= (w_wr_idx == m3sra_pkg::SLOT_W'(m3sra_pkg::RING_DEPTH - 1))
                          ? '0 : w_wr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_med.valid && i_scale_divisor == '0) begin
            r_scaled <= m3sra_pkg::WORD_MAX;
        end else if (r_state == ST_SCALE && w_div_rsp.done) begin
            r_scaled <= w_sat_quo;
        end
        if (r_state == ST_SUM && w_nz_cnt == '0) begin
            r_mean <= '0;
        end else if (r_state == ST_MEAN && w_div_rsp.done) begin
            r_mean <= w_div_rsp.quotient[m3sra_pkg::WORD_W-1:0];
        end
    end

    assign empty                      = (r_state != ST_HOLD);
    assign o_out_item.scaled_value    = r_scaled;
    assign o_out_item.mean_of_nonzero = r_mean;

    a_slot_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != m3sra_pkg::SLOT_W'(m3sra_pkg::RING_DEPTH))
        else $error("ring slot out of range");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_SCALE || r_state == ST_MEAN))
        else $error("divider finished with nobody waiting");

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD && !pop) |=> ($stable(r_scaled) && $stable(r_mean) && !empty))
        else $error("waiting result changed before pop");

endmodule

[rtl/median3_scale_rolling_average_core.sv]
// top level: median-of-three, scaling and rolling mean of nonzero ring entries
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  input    | push / full                | i_in_item  (three 10-bit samples)
//  result   | empty / pop                | o_out_item (scaled value, mean)
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (scale divisor)
//
// an item takes two passes of the 18-step serial divider, one to scale and one for the mean
// (a zero divisor or an all-zero ring each skips a pass)
// a two-entry median queue lets the front take requests while a result waits on pop
// synchronous active-low reset clears the ring, write slot and median queue, divisor returns to 29
// config writes are always ready
module median3_scale_rolling_average_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  m3sra_pkg::t_in_item              i_in_item,
    output logic                             empty,
    input  logic                             pop,
    output m3sra_pkg::t_out_item             o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [m3sra_pkg::DIVISOR_W-1:0]  i_cfg_data
);

    logic [m3sra_pkg::DIVISOR_W-1:0] r_scale_divisor;
    m3sra_pkg::t_med_item            w_med;
    logic                            w_med_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_divisor <= m3sra_pkg::DIVISOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_scale_divisor <= i_cfg_data;
        end
    end

    m3sra_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .o_med      (w_med),
        .i_med_take (w_med_take)
    );

    m3sra_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_med           (w_med),
        .o_med_take      (w_med_take),
        .i_scale_divisor (r_scale_divisor),
        .empty           (empty),
        .pop             (pop),
        .o_out_item      (o_out_item)
    );

endmodule

[dv/median3_scale_rolling_average_core_tb.sv]
// testbench for the median-of-three scaled rolling average core
module median3_scale_rolling_average_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_PERIODIC,
        RX_HEAVY
    } t_rx_mode;

    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            push      = 1'b0;
    logic                            full;
    m3sra_pkg::t_in_item             in_item   = '0;
    logic                            empty;
    logic                            pop       = 1'b0;
    m3sra_pkg::t_out_item            out_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [m3sra_pkg::DIVISOR_W-1:0] cfg_data  = '0;

    // mirror of the block's state
    logic [m3sra_pkg::WORD_W-1:0]    ring_model [m3sra_pkg::RING_DEPTH];
    int unsigned                     slot_model;
    logic [m3sra_pkg::DIVISOR_W-1:0] divisor_model;

    m3sra_pkg::t_out_item            expected_results [$];
    int unsigned                     fail_cnt   = 0;
    t_rx_mode                        rx_mode    = RX_FREE;
    logic [7:0]                      rx_tick    = '0;
    int unsigned                     burst_left = 0;

    median3_scale_rolling_average_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic m3sra_pkg::t_in_item make_triple(int unsigned a, int unsigned b,
                                                        int unsigned c);
        m3sra_pkg::t_in_item it;
        it.sample_first  = a[m3sra_pkg::SAMPLE_W-1:0];
        it.sample_second = b[m3sra_pkg::SAMPLE_W-1:0];
        it.sample_third  = c[m3sra_pkg::SAMPLE_W-1:0];
        return it;
    endfunction

    // max(min(a,b), min(max(a,b),c))
    function automatic logic [m3sra_pkg::SAMPLE_W-1:0] middle_sample(m3sra_pkg::t_in_item it);
        logic [m3sra_pkg::SAMPLE_W-1:0] lo;
        logic [m3sra_pkg::SAMPLE_W-1:0] hi;
        logic [m3sra_pkg::SAMPLE_W-1:0] cap;
        lo  = (it.sample_first < it.sample_second) ? it.sample_first : it.sample_second;
        hi  = (it.sample_first < it.sample_second) ? it.sample_second : it.sample_first;
        cap = (hi < it.sample_third) ? hi : it.sample_third;
        return (lo > cap) ? lo : cap;
    endfunction

    function automatic logic [m3sra_pkg::WORD_W-1:0] scaled_median(
        logic [m3sra_pkg::SAMPLE_W-1:0] m
    );
        int unsigned q;
        if (divisor_model == '0) begin
            return m3sra_pkg::WORD_MAX;
        end
        q = (int'(m) * 100) / int'(divisor_model);
        return (q > 32'hFFFF) ? m3sra_pkg::WORD_MAX : q[m3sra_pkg::WORD_W-1:0];
    endfunction

    task automatic reset_model();
        for (int k = 0; k < m3sra_pkg::RING_DEPTH; k++) begin
            ring_model[k] = '0;
        end
        slot_model    = 0;
        divisor_model = m3sra_pkg::DIVISOR_RESET;
    endtask

    task automatic predict_average(m3sra_pkg::t_in_item it);
        m3sra_pkg::t_out_item want;
        int unsigned          sum;
        int unsigned          count;
        want.scaled_value      = scaled_median(middle_sample(it));
        ring_model[slot_model] = want.scaled_value;
        slot_model             = (slot_model + 1) % m3sra_pkg::RING_DEPTH;
        sum   = 0;
        count = 0;
        for (int k = 0; k < m3sra_pkg::RING_DEPTH; k++) begin
            if (ring_model[k] != '0) begin
                sum   += ring_model[k];
                count++;
            end
        end
        want.mean_of_nonzero = (count == 0) ? '0 : m3sra_pkg::WORD_W'(sum / count);
        expected_results.push_back(want);
    endtask

    task automatic report_failure(string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_field(string name, logic [m3sra_pkg::WORD_W-1:0] want,
                               logic [m3sra_pkg::WORD_W-1:0] got);
        if (got !== want) begin
            report_failure($sformatf("mismatch on %s: expected %0d, got %0d", name, want, got));
        end
    endtask

    task automatic check_average(m3sra_pkg::t_out_item got);
        m3sra_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            report_failure($sformatf("result with nothing expected: scaled %0d, mean %0d",
                                     got.scaled_value, got.mean_of_nonzero));
        end else begin
            want = expected_results.pop_front();
            check_field("scaled_value", want.scaled_value, got.scaled_value);
            check_field("mean_of_nonzero", want.mean_of_nonzero, got.mean_of_nonzero);
        end
    endtask

    // result side: stall pattern is drawn anew at random each time the 8-bit rx_tick counter wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_average(out_item);
            end
            rx_tick <= rx_tick + 8'd1;
            if (rx_tick == '0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_FREE:     pop <= 1'b1;
                RX_LIGHT:    pop <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: pop <= (rx_tick[4:0] >= 5'd12);
                default:     pop <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // push stays high on return so a following request goes out back to back
    task automatic send_item(m3sra_pkg::t_in_item it);
        push    <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (full);
        predict_average(it);
    endtask

    task automatic hold_off(int unsigned cycles);
        if (cycles > 0) begin
            push <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_in_bursts(m3sra_pkg::t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                hold_off($urandom_range(1, 15));
            end
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic drain_results();
        int unsigned waited;
        push  <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_divisor(logic [m3sra_pkg::DIVISOR_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        divisor_model = value;
    endtask

    function automatic m3sra_pkg::t_in_item random_triple();
        int unsigned a;
        int unsigned style;
        style = $urandom_range(0, 9);
        a     = $urandom_range(0, 1023);
        case (style)
            6, 7:    return make_triple($urandom_range(0, 4), $urandom_range(0, 4),
                                        $urandom_range(0, 4));
            8:       return make_triple(a, a, $urandom_range(0, 1023));
            9:       return make_triple(a, a, a);
            default: return make_triple($urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 1023));
        endcase
    endfunction

    task automatic test_reset_extremes();
        send_item(make_triple(0, 0, 0));
        send_item(make_triple(1023, 1023, 1023));
        send_item(make_triple(0, 1023, 512));
        send_item(make_triple(512, 0, 1023));
        send_item(make_triple(1023, 512, 0));
        send_item(make_triple(7, 7, 900));
        send_item(make_triple(1, 1, 1));
        send_item(make_triple(0, 0, 1023));
        send_item(make_triple(1023, 0, 0));
        send_item(make_triple(10'h2AA, 10'h155, 10'h3FF));
        send_item(make_triple(10'h155, 10'h3FF, 10'h2AA));
        drain_results();
    endtask

    task automatic test_divisor_extremes();
        // divisor one saturates above a median of 655
        write_divisor(8'd1);
        send_item(make_triple(655, 655, 655));
        send_item(make_triple(656, 700, 10));
        send_item(make_triple(1023, 1023, 1023));
        send_item(make_triple(0, 0, 0));
        // divisor zero gives full scale even for a zero median
        write_divisor(8'd0);
        send_item(make_triple(0, 0, 0));
        send_item(make_triple(300, 1, 2));
        write_divisor(8'd255);
        send_item(make_triple(2, 2, 2));
        send_item(make_triple(1023, 1023, 1023));
        write_divisor(8'd2);
        send_item(make_triple(1023, 1023, 1023));
        send_item(make_triple(1, 0, 1));
        drain_results();
    endtask

    task automatic test_drain_pause();
        write_divisor(m3sra_pkg::DIVISOR_RESET);
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 10; i++) begin
                send_item(random_triple());
            end
            drain_results();
        end
    endtask

    task automatic test_random_phases();
        logic [m3sra_pkg::DIVISOR_W-1:0] divisors [8];
        int unsigned                     count;
        divisors[0] = m3sra_pkg::DIVISOR_W'($urandom_range(2, 255));
        divisors[1] = 8'd255;
        divisors[2] = 8'd2;
        divisors[3] = 8'd1;
        divisors[4] = m3sra_pkg::DIVISOR_W'($urandom_range(2, 255));
        divisors[5] = 8'd0;
        divisors[6] = m3sra_pkg::DIVISOR_RESET;
        divisors[7] = m3sra_pkg::DIVISOR_W'($urandom_range(2, 255));
        foreach (divisors[p]) begin
            write_divisor(divisors[p]);
            burst_left = 0;
            count      = $urandom_range(150, 230);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(0, 149) == 0) begin
                    drain_results();
                end
                send_in_bursts(random_triple());
            end
        end
        drain_results();
    endtask

    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_extremes();
        test_divisor_extremes();
        test_drain_pause();
        test_random_phases();
        drain_results();
        while (expected_results.size() != 0) begin
            void'(expected_results.pop_front());
            report_failure("expected result never arrived");
        end
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
